// File: design/alpha_weighted_area_downscaler_top_defines.svh
// assertion macros used by the downscaler controller
`ifndef ALPHA_WEIGHTED_AREA_DOWNSCALER_TOP_DEFINES_SVH
`define ALPHA_WEIGHTED_AREA_DOWNSCALER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/awd_pkg.sv
// types and constants of the alpha weighted area downscaler
package awd_pkg;

    localparam int DIM_W     = 13;  // source width and height
    localparam int MAX_W     = 10;  // max edge and output size
    localparam int POS_W     = 24;  // scaled coordinates
    localparam int WGT_W     = 10;  // overlap per axis
    localparam int AW1_W     = 18;  // alpha times x overlap
    localparam int AWT_W     = 28;  // full alpha weight
    localparam int PRD_W     = 36;  // colour times alpha weight
    localparam int SUMA_W    = 34;
    localparam int SUMC_W    = 42;
    localparam int SUM_W     = SUMA_W + 3 * SUMC_W;
    localparam int NUM_W     = 44;
    localparam int DEN_W     = 35;
    localparam int QUO_W     = 10;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE   = 8'd2;

    typedef enum logic [2:0] {
        JOB_DW = 3'd0,
        JOB_DH = 3'd1,
        JOB_B  = 3'd2,
        JOB_G  = 3'd3,
        JOB_R  = 3'd4,
        JOB_A  = 3'd5
    } t_job;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic [7:0] in_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic [7:0]  out_alpha;
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        frame_last;
    } t_out_item;

    typedef struct packed {
        logic       clr;
        logic       accept;
        logic       rd;
        logic       mul;
        logic       prd;
        logic       wr;
        logic [1:0] slot;
        logic       div_start;
        t_job       job;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic pass;
        logic spanx;
        logic spany;
        logic emit;
        logic out_free;
    } t_status;

endpackage

// File: design/awd_ram.sv
// generic single write port ram with registered read
module awd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/awd_div.sv
// restoring divider, one quotient bit per cycle
module awd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_abort,
    input  logic                      i_start,
    input  logic [awd_pkg::NUM_W-1:0] i_num,
    input  logic [awd_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [awd_pkg::QUO_W-1:0] o_quo
);
    import awd_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_trial;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             ge;

    assign ge     = (r_rem >= r_trial);
    assign o_done = r_busy && (r_cnt == CNT_LAST);
    assign o_quo  = {r_quo[QUO_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_abort) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num;
            r_trial <= NUM_W'(i_den) << (QUO_W - 1);
            r_quo   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_trial;
            end
            r_trial <= r_trial >> 1;
            r_quo   <= {r_quo[QUO_W-2:0], ge};
        end
    end
endmodule

// File: design/awd_ctrl.sv
// controller state machine of the downscaler
`include "alpha_weighted_area_downscaler_top_defines.svh"
module awd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_accept,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  awd_pkg::t_status i_status,
    output awd_pkg::t_cmd    o_cmd
);
    import awd_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_DGO   = 9'b000000010,
        S_DWAIT = 9'b000000100,
        S_IDLE  = 9'b000001000,
        S_RD    = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_PRD   = 9'b001000000,
        S_WR    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cell, n_cell;
    t_job       r_job, n_job;
    logic       cells_done;

    always_comb begin
        n_state    = r_state;
        n_cell     = r_cell;
        n_job      = r_job;
        o_cmd      = '0;
        o_cmd.slot = r_cell;
        o_cmd.job  = r_job;
        o_in_ready = 1'b0;
        cells_done = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_DGO;
                    n_job   = JOB_DW;
                end
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_DGO;
                    case (r_job)
                        JOB_DW:  n_job = JOB_DH;
                        JOB_DH:  n_state = S_IDLE;
                        JOB_B:   n_job = JOB_G;
                        JOB_G:   n_job = JOB_R;
                        JOB_R:   n_job = JOB_A;
                        JOB_A:   n_state = S_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cell       = 2'd0;
                    n_state      = i_status.pass ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PRD;
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_RD;
                case (r_cell)
                    2'd0: begin
                        if (i_status.spanx) begin
                            n_cell = 2'd1;
                        end else if (i_status.spany) begin
                            n_cell = 2'd2;
                        end else begin
                            cells_done = 1'b1;
                        end
                    end
                    2'd1: begin
                        if (i_status.spany) begin
                            n_cell = 2'd2;
                        end else begin
                            cells_done = 1'b1;
                        end
                    end
                    2'd2: begin
                        if (i_status.spanx) begin
                            n_cell = 2'd3;
                        end else begin
                            cells_done = 1'b1;
                        end
                    end
                    default: cells_done = 1'b1;
                endcase
                if (cells_done) begin
                    if (i_status.emit) begin
                        n_state = S_DGO;
                        n_job   = JOB_B;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // a register write restarts the frame
        if (i_cfg_accept) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cell  <= 2'd0;
            r_job   <= JOB_DW;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
            r_job   <= n_job;
        end
    end

    `AWD_ASSERT_NEXT(a_cfg_clears, i_cfg_accept, r_state == S_CLEAR, "write did not restart")
    `AWD_ASSERT_NOW(a_div_wait, i_status.div_done, r_state == S_DWAIT, "stray divider done")
    `AWD_ASSERT_NOW(a_cell_four, (r_state == S_RD) && (r_cell == 2'd3),
                    i_status.spanx && i_status.spany, "fourth cell without two spans")
    `AWD_ASSERT_NEXT(a_pass_out,
                     (r_state == S_IDLE) && i_in_valid && i_status.pass && !i_cfg_accept,
                     r_state == S_OUT, "pass-through item missed output")
endmodule

// File: design/awd_dp.sv
// datapath: registers, position tracking, sum memory and divider
module awd_dp #(
    parameter int MAX_OUT_EDGE = 512,
    parameter int MAX_IN_EDGE  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_accept,
    input  logic [awd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [awd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  awd_pkg::t_in_item             i_in_data,
    input  awd_pkg::t_cmd                 i_cmd,
    output awd_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output awd_pkg::t_out_item            o_out_data
);
    import awd_pkg::*;

    localparam int DEPTH  = 2 * MAX_OUT_EDGE;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_IN_EDGE) begin
            res = DIM_W'(MAX_IN_EDGE);
        end
        return res;
    endfunction

    function automatic logic [MAX_W-1:0] sat_max(input logic [MAX_W-1:0] v);
        logic [MAX_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = MAX_W'(1);
        end else if (int'(v) > MAX_OUT_EDGE) begin
            res = MAX_W'(MAX_OUT_EDGE);
        end
        return res;
    endfunction

    // configuration and output size
    logic [DIM_W-1:0] r_w, r_h;
    logic [MAX_W-1:0] r_m, r_dw, r_dh;

    // position of the next source pixel
    logic [DIM_W-1:0] r_col, r_row;
    logic [POS_W-1:0] r_x_lo, r_x_bx, r_y_lo, r_y_by;
    logic [MAX_W-1:0] r_xf, r_yf;

    // latched item
    t_in_item         r_px;
    logic [WGT_W-1:0] r_wx0, r_wx1, r_wy0, r_wy1;
    logic             r_spanx, r_spany, r_cmplx, r_cmply;
    logic [DIM_W-1:0] r_icol, r_irow;
    logic [MAX_W-1:0] r_ixf, r_iyf;
    logic             r_item_pass, r_last;

    // update pipeline
    logic [ADDR_W-1:0] r_addr, r_clr_addr;
    logic [AW1_W-1:0]  r_aw1;
    logic [AWT_W-1:0]  r_aw;
    logic [PRD_W-1:0]  r_pb, r_pg, r_pr;
    logic [SUMA_W-1:0] r_sa;
    logic [SUMC_W-1:0] r_sb, r_sg, r_sr;
    logic [7:0]        r_ob, r_og, r_or, r_oa;

    logic      r_out_valid;
    t_out_item r_out_data;

    logic             pass;
    logic [DIM_W-1:0] longer;
    logic [POS_W-1:0] x_hi, y_hi;
    logic             spanx, spany, cmplx, cmply, col_end, row_end;
    logic [WGT_W-1:0] wx0, wx1, wy0, wy1, wx_sel, wy_sel;
    logic [MAX_W-1:0] cell_x;
    logic             bank;
    logic [ADDR_W-1:0] rd_addr;
    logic [SUM_W-1:0]  rdata, wdata;
    logic [SUMA_W-1:0] na;
    logic [SUMC_W-1:0] nb, ng, nr;
    logic              emit_now;
    logic [DIM_W+MAX_W-1:0] wm, hm;
    logic [2*DIM_W-1:0]     area;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [7:0]        qc;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;

    assign pass   = (DIM_W'(r_m) >= r_w) && (DIM_W'(r_m) >= r_h);
    assign longer = (r_w > r_h) ? r_w : r_h;

    // source pixel span against the output cell boundary
    assign x_hi    = r_x_lo + POS_W'(r_dw);
    assign y_hi    = r_y_lo + POS_W'(r_dh);
    assign spanx   = x_hi > r_x_bx;
    assign spany   = y_hi > r_y_by;
    assign cmplx   = x_hi >= r_x_bx;
    assign cmply   = y_hi >= r_y_by;
    assign wx0     = spanx ? WGT_W'(r_x_bx - r_x_lo) : r_dw;
    assign wx1     = WGT_W'(x_hi - r_x_bx);
    assign wy0     = spany ? WGT_W'(r_y_by - r_y_lo) : r_dh;
    assign wy1     = WGT_W'(y_hi - r_y_by);
    assign col_end = (r_col == r_w - 1'b1);
    assign row_end = (r_row == r_h - 1'b1);

    assign wx_sel  = i_cmd.slot[0] ? r_wx1 : r_wx0;
    assign wy_sel  = i_cmd.slot[1] ? r_wy1 : r_wy0;
    assign cell_x  = r_ixf + MAX_W'(i_cmd.slot[0]);
    assign bank    = r_iyf[0] ^ i_cmd.slot[1];
    assign rd_addr = bank ? (ADDR_W'(MAX_OUT_EDGE) + ADDR_W'(cell_x)) : ADDR_W'(cell_x);

    assign na = rdata[SUM_W-1 -: SUMA_W] + SUMA_W'(r_aw);
    assign nb = rdata[3*SUMC_W-1 -: SUMC_W] + SUMC_W'(r_pb);
    assign ng = rdata[2*SUMC_W-1 -: SUMC_W] + SUMC_W'(r_pg);
    assign nr = rdata[SUMC_W-1:0] + SUMC_W'(r_pr);

    // the completed cell is always the first one, cleared as it is written
    assign emit_now  = r_cmplx && r_cmply && (i_cmd.slot == 2'd0);
    assign wdata     = (i_cmd.clr || emit_now) ? '0 : {na, nb, ng, nr};
    assign ram_we    = i_cmd.clr || i_cmd.wr;
    assign ram_waddr = i_cmd.clr ? r_clr_addr : r_addr;

    awd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign wm   = r_w * r_m;
    assign hm   = r_h * r_m;
    assign area = r_w * r_h;

    always_comb begin
        case (i_cmd.job)
            JOB_DW: begin
                div_num = NUM_W'({wm, 1'b0}) + NUM_W'(longer);
                div_den = DEN_W'({longer, 1'b0});
            end
            JOB_DH: begin
                div_num = NUM_W'({hm, 1'b0}) + NUM_W'(longer);
                div_den = DEN_W'({longer, 1'b0});
            end
            JOB_B: begin
                div_num = NUM_W'({r_sb, 1'b0}) + NUM_W'(r_sa);
                div_den = DEN_W'({r_sa, 1'b0});
            end
            JOB_G: begin
                div_num = NUM_W'({r_sg, 1'b0}) + NUM_W'(r_sa);
                div_den = DEN_W'({r_sa, 1'b0});
            end
            JOB_R: begin
                div_num = NUM_W'({r_sr, 1'b0}) + NUM_W'(r_sa);
                div_den = DEN_W'({r_sa, 1'b0});
            end
            JOB_A: begin
                div_num = NUM_W'({r_sa, 1'b0}) + NUM_W'(area);
                div_den = DEN_W'({area, 1'b0});
            end
            default: begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    awd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_abort (i_cfg_accept),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign qc = (div_quo > QUO_W'(255)) ? 8'hFF : div_quo[7:0];

    // configuration, output size and source position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= DIM_W'(1);
            r_h        <= DIM_W'(1);
            r_m        <= sat_max(MAX_W'(512));
            r_dw       <= MAX_W'(1);
            r_dh       <= MAX_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_x_lo     <= '0;
            r_y_lo     <= '0;
            r_x_bx     <= POS_W'(1);
            r_y_by     <= POS_W'(1);
            r_xf       <= '0;
            r_yf       <= '0;
            r_clr_addr <= '0;
        end else if (i_cfg_accept) begin
            r_clr_addr <= '0;
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_w <= sat_dim(i_cfg_data);
                REG_SRC_HEIGHT: r_h <= sat_dim(i_cfg_data);
                REG_MAX_EDGE:   r_m <= sat_max(i_cfg_data[MAX_W-1:0]);
                default:        r_clr_addr <= '0;
            endcase
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (div_done && (i_cmd.job == JOB_DW)) begin
                r_dw <= pass ? r_w[MAX_W-1:0] : ((div_quo == '0) ? MAX_W'(1) : div_quo);
            end
            if (div_done && (i_cmd.job == JOB_DH)) begin
                r_dh   <= pass ? r_h[MAX_W-1:0] : ((div_quo == '0) ? MAX_W'(1) : div_quo);
                r_col  <= '0;
                r_row  <= '0;
                r_x_lo <= '0;
                r_y_lo <= '0;
                r_x_bx <= POS_W'(r_w);
                r_y_by <= POS_W'(r_h);
                r_xf   <= '0;
                r_yf   <= '0;
            end
            if (i_cmd.accept) begin
                if (col_end) begin
                    r_col  <= '0;
                    r_x_lo <= '0;
                    r_x_bx <= POS_W'(r_w);
                    r_xf   <= '0;
                    if (row_end) begin
                        r_row  <= '0;
                        r_y_lo <= '0;
                        r_y_by <= POS_W'(r_h);
                        r_yf   <= '0;
                    end else begin
                        r_row  <= r_row + 1'b1;
                        r_y_lo <= y_hi;
                        if (cmply) begin
                            r_yf   <= r_yf + 1'b1;
                            r_y_by <= r_y_by + POS_W'(r_h);
                        end
                    end
                end else begin
                    r_col  <= r_col + 1'b1;
                    r_x_lo <= x_hi;
                    if (cmplx) begin
                        r_xf   <= r_xf + 1'b1;
                        r_x_bx <= r_x_bx + POS_W'(r_w);
                    end
                end
            end
        end
    end

    // item latch, weight pipeline and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px        <= i_in_data;
            r_wx0       <= wx0;
            r_wx1       <= wx1;
            r_wy0       <= wy0;
            r_wy1       <= wy1;
            r_spanx     <= spanx;
            r_spany     <= spany;
            r_cmplx     <= cmplx;
            r_cmply     <= cmply;
            r_icol      <= r_col;
            r_irow      <= r_row;
            r_ixf       <= r_xf;
            r_iyf       <= r_yf;
            r_item_pass <= pass;
            r_last      <= pass ? (col_end && row_end)
                                : ((r_xf == r_dw - 1'b1) && (r_yf == r_dh - 1'b1));
        end
        if (i_cmd.rd) begin
            r_addr <= rd_addr;
            r_aw1  <= AW1_W'(r_px.in_alpha * wx_sel);
        end
        if (i_cmd.mul) begin
            r_aw <= AWT_W'(r_aw1 * wy_sel);
        end
        if (i_cmd.prd) begin
            r_pb <= PRD_W'(r_px.in_blue * r_aw);
            r_pg <= PRD_W'(r_px.in_green * r_aw);
            r_pr <= PRD_W'(r_px.in_red * r_aw);
        end
        if (i_cmd.wr && (i_cmd.slot == 2'd0)) begin
            r_sa <= na;
            r_sb <= nb;
            r_sg <= ng;
            r_sr <= nr;
        end
        if (div_done) begin
            case (i_cmd.job)
                JOB_B:   r_ob <= (r_sa == '0) ? 8'd0 : qc;
                JOB_G:   r_og <= (r_sa == '0) ? 8'd0 : qc;
                JOB_R:   r_or <= (r_sa == '0) ? 8'd0 : qc;
                JOB_A:   r_oa <= qc;
                default: r_oa <= r_oa;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.frame_last <= r_last;
            if (r_item_pass) begin
                r_out_data.out_blue  <= r_px.in_blue;
                r_out_data.out_green <= r_px.in_green;
                r_out_data.out_red   <= r_px.in_red;
                r_out_data.out_alpha <= r_px.in_alpha;
                r_out_data.out_col   <= r_icol[11:0];
                r_out_data.out_row   <= r_irow[11:0];
            end else begin
                r_out_data.out_blue  <= r_ob;
                r_out_data.out_green <= r_og;
                r_out_data.out_red   <= r_or;
                r_out_data.out_alpha <= r_oa;
                r_out_data.out_col   <= 12'(r_ixf);
                r_out_data.out_row   <= 12'(r_iyf);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_status.div_done = div_done;
    assign o_status.pass     = pass;
    assign o_status.spanx    = r_spanx;
    assign o_status.spany    = r_spany;
    assign o_status.emit     = r_cmplx && r_cmply;
    assign o_status.out_free = !r_out_valid || i_out_ready;
endmodule

// File: design/alpha_weighted_area_downscaler_top.sv
// top level of the alpha weighted area downscaler
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_in_data  (bgra source pixel)
//  out     | source    | o_out_valid / i_out_ready  | o_out_data (pixel, col, row, last)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// pass-through pixel: accept, then load of the output register
// downscaled pixel: accept, then read, multiply, product and write of the sum memory for
//   each touched output cell (1 to 4 cells), a read-modify-write per cell
// a pixel that completes a box adds four serial divisions, each a start and then the
//   quotient steps, then a load of the output register
// after reset and after every register write: a clearing pass over all 2*MAX_OUT_EDGE
//   words of the sum memory, then two divisions to size the output; no pixel is taken
// a stalled output register holds its result; a new result then waits, so no pixel is taken
module alpha_weighted_area_downscaler_top #(
    parameter int MAX_OUT_EDGE = 512,
    parameter int MAX_IN_EDGE  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  awd_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output awd_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [awd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [awd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import awd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_accept;

    // register writes are always taken; each one restarts the frame
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    // sequencing of clear, sizing, accumulation and division
    awd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_accept (cfg_accept),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // position tracking, sum memory, divider and output register
    awd_dp #(
        .MAX_OUT_EDGE (MAX_OUT_EDGE),
        .MAX_IN_EDGE  (MAX_IN_EDGE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_accept (cfg_accept),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (i_in_data),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );
endmodule

// File: verif/tb_alpha_weighted_area_downscaler_top.sv
// testbench of the alpha weighted area downscaler top level
`timescale 1ns / 100ps

module tb_alpha_weighted_area_downscaler_top;
    import awd_pkg::*;

    localparam int OUT_EDGE  = 512;
    localparam int IN_EDGE   = 4096;
    localparam int DRAIN_CYC = 120;    // longest in-flight pixel: 4 cells plus division
    localparam int WD_LIMIT  = 20000;  // idle cycles, covers clearing pass and stalls
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_MAX_EDGE + 1;

    // area-average predictor with its own copy of registers and sums
    class downscale_scoreboard;
        int unsigned reg_w, reg_h, reg_m;
        longint unsigned col, row, dst_w, dst_h;
        longint unsigned a_acc[2*OUT_EDGE], b_acc[2*OUT_EDGE];
        longint unsigned g_acc[2*OUT_EDGE], r_acc[2*OUT_EDGE];
        t_out_item pixels_due[$];
        int errors;
        int matched;

        function new();
            errors = 0;
            matched = 0;
            reg_w = 1;
            reg_h = 1;
            reg_m = OUT_EDGE;
            restart();
        endfunction

        function longint unsigned clip(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function longint unsigned overlap(longint unsigned s, longint unsigned k,
                                          longint unsigned len, longint unsigned d);
            longint unsigned lo, hi;
            lo = (k * len > s * d) ? k * len : s * d;
            hi = ((k + 1) * len < (s + 1) * d) ? (k + 1) * len : (s + 1) * d;
            return (hi > lo) ? hi - lo : 0;
        endfunction

        function void restart();
            longint unsigned w, h, m, lg;
            w = clip(reg_w, IN_EDGE);
            h = clip(reg_h, IN_EDGE);
            m = clip(reg_m, OUT_EDGE);
            lg = (w > h) ? w : h;
            col = 0;
            row = 0;
            for (int i = 0; i < 2*OUT_EDGE; i++) begin
                a_acc[i] = 0; b_acc[i] = 0; g_acc[i] = 0; r_acc[i] = 0;
            end
            if (w <= m && h <= m) begin
                dst_w = w;
                dst_h = h;
            end else begin
                dst_w = (2 * w * m + lg) / (2 * lg);
                dst_h = (2 * h * m + lg) / (2 * lg);
                if (dst_w < 1) dst_w = 1;
                if (dst_h < 1) dst_h = 1;
            end
        endfunction

        // any write, known index or not, restarts the frame
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_SRC_WIDTH) reg_w = data;
            else if (idx == REG_SRC_HEIGHT) reg_h = data;
            else if (idx == REG_MAX_EDGE) reg_m = data[MAX_W-1:0];
            restart();
        endfunction

        function longint unsigned avg8(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = (2 * num + den) / (2 * den);
            return (q > 255) ? 255 : q;
        endfunction

        function void note_input(t_in_item px);
            longint unsigned w, h, m, sx, sy, xf, xl, yf, yl, wy, aw, idx, sa, area;
            t_out_item res;
            w = clip(reg_w, IN_EDGE);
            h = clip(reg_h, IN_EDGE);
            m = clip(reg_m, OUT_EDGE);
            sx = col;
            sy = row;
            if (sx >= w || sy >= h) begin
                sx = 0;
                sy = 0;
            end
            if (w <= m && h <= m) begin
                res.out_blue = px.in_blue;
                res.out_green = px.in_green;
                res.out_red = px.in_red;
                res.out_alpha = px.in_alpha;
                res.out_col = sx[11:0];
                res.out_row = sy[11:0];
                res.frame_last = (sx == w - 1 && sy == h - 1);
                pixels_due.push_back(res);
            end else begin
                xf = sx * dst_w / w;
                xl = ((sx + 1) * dst_w - 1) / w;
                yf = sy * dst_h / h;
                yl = ((sy + 1) * dst_h - 1) / h;
                for (longint unsigned yy = yf; yy <= yl; yy++) begin
                    wy = overlap(sy, yy, h, dst_h);
                    for (longint unsigned xx = xf; xx <= xl; xx++) begin
                        aw = px.in_alpha * overlap(sx, xx, w, dst_w) * wy;
                        idx = (yy % 2) * OUT_EDGE + xx;
                        if (xx < OUT_EDGE) begin
                            a_acc[idx] += aw;
                            b_acc[idx] += px.in_blue * aw;
                            g_acc[idx] += px.in_green * aw;
                            r_acc[idx] += px.in_red * aw;
                        end
                    end
                end
                // box of the first touched cell closes on this pixel
                if ((xf + 1) * w <= (sx + 1) * dst_w && (yf + 1) * h <= (sy + 1) * dst_h
                        && xf < OUT_EDGE) begin
                    idx = (yf % 2) * OUT_EDGE + xf;
                    sa = a_acc[idx];
                    area = w * h;
                    if (sa > 0) begin
                        res.out_blue = avg8(b_acc[idx], sa);
                        res.out_green = avg8(g_acc[idx], sa);
                        res.out_red = avg8(r_acc[idx], sa);
                    end else begin
                        res.out_blue = 0;
                        res.out_green = 0;
                        res.out_red = 0;
                    end
                    res.out_alpha = avg8(sa, area);
                    res.out_col = xf[11:0];
                    res.out_row = yf[11:0];
                    res.frame_last = (xf == dst_w - 1 && yf == dst_h - 1);
                    a_acc[idx] = 0; b_acc[idx] = 0; g_acc[idx] = 0; r_acc[idx] = 0;
                    pixels_due.push_back(res);
                end
            end
            sx++;
            if (sx >= w) begin
                sx = 0;
                sy++;
                if (sy >= h) sy = 0;
            end
            col = sx;
            row = sy;
        endfunction

        function void field(string nm, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            int before_err;
            if (pixels_due.size() == 0) begin
                $display("%0t unexpected output pixel expected none actual %h", $time, got);
                errors++;
                return;
            end
            e = pixels_due.pop_front();
            before_err = errors;
            field("out_blue", e.out_blue, got.out_blue);
            field("out_green", e.out_green, got.out_green);
            field("out_red", e.out_red, got.out_red);
            field("out_alpha", e.out_alpha, got.out_alpha);
            field("out_col", e.out_col, got.out_col);
            field("out_row", e.out_row, got.out_row);
            field("frame_last", e.frame_last, got.frame_last);
            if (errors == before_err) matched++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    downscale_scoreboard sb = new();
    bit quiet = 1'b0;        // no idling on either side while set
    int idle_cycles = 0;
    int pixels_sent = 0;
    int reg_writes = 0;

    alpha_weighted_area_downscaler_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver stalls about 12 percent of the time, never while quiet is set
    always @(posedge i_clk) begin
        i_out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // output transfers are checked against the oldest predicted pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("%0t watchdog expired, %0d pixels still due", $time,
                     sb.pixels_due.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender gap, drops valid only when a gap actually happens
    task automatic sender_gap();
        if (!quiet && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
    endtask

    task automatic send_pixel(t_in_item px);
        i_in_valid <= 1'b1;
        i_in_data <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(px);
        pixels_sent++;
        sender_gap();
    endtask

    // random pixel with extra weight on transparent and opaque alpha
    task automatic send_random(int n);
        t_in_item px;
        for (int i = 0; i < n; i++) begin
            px = t_in_item'($urandom);
            case ($urandom_range(7))
                0, 1: px.in_alpha = 8'd0;
                2:    px.in_alpha = 8'd255;
                default: ;
            endcase
            send_pixel(px);
        end
    endtask

    // holds off until the block is idle: all pixels out, last one drained
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_image(int w, int h, int m);
        wait_drained();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_MAX_EDGE, m);
        // writes outside the register list still restart the frame
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED + $urandom_range(252), $urandom);
    endtask

    initial begin
        int w, h, m;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 1x1 pass-through, every pixel is a frame end
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'hAA55AA55);
        send_pixel(32'h55AA55AA);
        send_pixel(32'h00FF00FF);
        // small pass-through frame
        set_image(3, 2, 512);
        send_random(6);
        // downscale with a fully transparent box, then opaque white
        set_image(4, 4, 2);
        for (int i = 0; i < 8; i++) send_pixel({8'd200, 8'd100, 8'd50, 8'd0});
        for (int i = 0; i < 8; i++) send_pixel('1);
        // max edge of one, whole frame to a single pixel
        set_image(5, 3, 1);
        send_random(15);
        // widest source, and out-of-range register values that saturate
        set_image(4096, 1, 512);
        send_random(80);
        set_image(0, 8191, 1023);
        send_random(64);
        set_image(600, 3, 0);
        send_random(40);

        // random frames, mostly small downscales with complete boxes
        for (int ph = 0; pixels_sent < 2000; ph++) begin
            quiet = (ph >= 10 && ph < 20);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            m = ($urandom_range(5) == 0) ? $urandom_range(8, 512) : $urandom_range(1, 8);
            set_image(w, h, m);
            send_random(w * h * $urandom_range(1, 3) + $urandom_range(2));
        end
        quiet = 1'b0;

        wait_drained();
        $display("covered %0d source pixels over %0d register writes,", pixels_sent,
                 reg_writes);
        $display("%0d output pixels matched, pass-through and area downscale", sb.matched);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
